FILE: rtl/iis_pkg.sv
`default_nettype none

package iis_pkg;

	// Largest row the line buffer holds.
	localparam int unsigned MAX_WIDTH = 1024;
	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	// Column counter plus one, able to hold the width itself.
	localparam int unsigned CNT_W = COL_W + 1;

	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned EFF_W = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
	localparam int unsigned ROW_SUM_W = PIXEL_W + COL_W;
	localparam int unsigned ROW_SQ_W = 2 * PIXEL_W + COL_W;
	localparam int unsigned AREA_W = 28;
	localparam int unsigned SQUARE_W = 36;

	localparam int unsigned PADDR_W = 2;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned REG_IMAGE_WIDTH = 0;
	localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = WIDTH_REG_W'(1024);

	typedef logic [COL_W-1:0] col_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last_of_frame;
	} pixel_in_t;

	typedef struct packed {
		logic [AREA_W-1:0]   area_sum;
		logic [SQUARE_W-1:0] square_sum;
		logic                frame_end;
	} result_t;

	// One line buffer entry: both integrals of the row above.
	typedef struct packed {
		logic [AREA_W-1:0]   area;
		logic [SQUARE_W-1:0] square;
	} lb_entry_t;

	typedef struct packed {
		logic rd_en;
		col_t rd_addr;
		logic wr_en;
		col_t wr_addr;
	} lb_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/iis_line_buffer.sv
`default_nettype none

module iis_line_buffer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire iis_pkg::lb_ctrl_t  ctrl,
	input  wire iis_pkg::lb_entry_t wr_data,
	output iis_pkg::lb_entry_t      rd_data
);

	iis_pkg::lb_entry_t mem [iis_pkg::MAX_WIDTH];
	iis_pkg::lb_entry_t rd_q;
	iis_pkg::lb_entry_t fwd_data_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.rd_addr];
		end
	end

	// A read that meets a write to the same entry in one cycle sees old data,
	// so the written value is captured and replaces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctrl.rd_en) begin
			fwd_q <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

FILE: rtl/integral_image_stream.sv
// Channel  | Direction | Handshake                   | Payload
// pix      | in        | pix_valid / pix_ready       | iis_pkg::pixel_in_t
// res      | out       | res_valid / res_ready       | iis_pkg::result_t
// APB      | in        | psel penable pwrite pready  | image_width at address 0
//
// One pixel is taken per cycle while pix_ready is high; each result passes through stage one and the output register.
// The rate is set by the line buffer: one read at intake, one write-back from stage one.
// Reset clears the column, the row sums and the first-row flag; no clearing pass runs.
// A stalled result holds stage one, and intake stops only once stage one is also full.
`default_nettype none

module integral_image_stream (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire iis_pkg::pixel_in_t            pix,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output iis_pkg::result_t                   res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iis_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [iis_pkg::PDATA_W-1:0]   pwdata,
	output logic [iis_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	// Configuration register. There is a single register, so every address
	// within the port's range selects it.
	logic [iis_pkg::WIDTH_REG_W-1:0] width_q;
	logic                            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = ((32'(paddr) >> 2) == iis_pkg::REG_IMAGE_WIDTH);
	assign prdata  = reg_sel ? iis_pkg::PDATA_W'(width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= iis_pkg::IMAGE_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			width_q <= pwdata[iis_pkg::WIDTH_REG_W-1:0];
		end
	end

	// The effective width clamps zero up to one and large values down to the
	// line buffer depth.
	logic [iis_pkg::EFF_W-1:0] width_ext;
	logic [iis_pkg::EFF_W-1:0] eff_width;

	assign width_ext = iis_pkg::EFF_W'(width_q);

	always_comb begin
		priority if (width_ext == '0) begin
			eff_width = iis_pkg::EFF_W'(1);
		end else if (width_ext > iis_pkg::EFF_W'(iis_pkg::MAX_WIDTH)) begin
			eff_width = iis_pkg::EFF_W'(iis_pkg::MAX_WIDTH);
		end else begin
			eff_width = width_ext;
		end
	end

	// Intake stage: the row running sums advance on every transfer and restart at a
	// row or frame end, and the line buffer entry of the same column is read.
	iis_pkg::col_t                 col_q;
	logic                          first_row_q;
	logic [iis_pkg::ROW_SUM_W-1:0] row_sum_q;
	logic [iis_pkg::ROW_SQ_W-1:0]  row_sq_q;

	logic                            accept;
	logic [2*iis_pkg::PIXEL_W-1:0]   pix_sq;
	logic [iis_pkg::ROW_SUM_W-1:0]   row_sum_nxt;
	logic [iis_pkg::ROW_SQ_W-1:0]    row_sq_nxt;
	logic [iis_pkg::CNT_W-1:0]       col_plus1;
	logic                            row_end;

	assign accept      = pix_valid && pix_ready;
	assign pix_sq      = pix.pixel * pix.pixel;
	assign row_sum_nxt = row_sum_q + iis_pkg::ROW_SUM_W'(pix.pixel);
	assign row_sq_nxt  = row_sq_q + iis_pkg::ROW_SQ_W'(pix_sq);
	assign col_plus1   = iis_pkg::CNT_W'(col_q) + iis_pkg::CNT_W'(1);
	assign row_end     = iis_pkg::EFF_W'(col_plus1) >= eff_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			row_sum_q   <= '0;
			row_sq_q    <= '0;
		end else if (accept) begin
			priority if (pix.last_of_frame) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
				row_sum_q   <= '0;
				row_sq_q    <= '0;
			end else if (row_end) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
				row_sum_q   <= '0;
				row_sq_q    <= '0;
			end else begin
				col_q     <= col_plus1[iis_pkg::COL_W-1:0];
				row_sum_q <= row_sum_nxt;
				row_sq_q  <= row_sq_nxt;
			end
		end
	end

	// Stage one: the line buffer data has arrived; the sum with the row
	// running value is written back to the same column and handed to the
	// output register in the same cycle.
	logic                          v_s1;
	iis_pkg::col_t                 col_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic [iis_pkg::ROW_SUM_W-1:0] row_sum_s1;
	logic [iis_pkg::ROW_SQ_W-1:0]  row_sq_s1;

	logic adv;

	assign adv       = !res_valid || res_ready;
	assign pix_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_ready) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col_q;
			first_s1   <= first_row_q;
			last_s1    <= pix.last_of_frame;
			row_sum_s1 <= row_sum_nxt;
			row_sq_s1  <= row_sq_nxt;
		end
	end

	iis_pkg::lb_ctrl_t  lb_ctrl;
	iis_pkg::lb_entry_t lb_rd;
	iis_pkg::lb_entry_t lb_wr;
	logic [iis_pkg::AREA_W-1:0]   above;
	logic [iis_pkg::SQUARE_W-1:0] above_sq;

	// The first row of a frame ignores whatever the buffer holds.
	assign above    = first_s1 ? '0 : lb_rd.area;
	assign above_sq = first_s1 ? '0 : lb_rd.square;

	assign lb_wr.area   = iis_pkg::AREA_W'(row_sum_s1) + above;
	assign lb_wr.square = iis_pkg::SQUARE_W'(row_sq_s1) + above_sq;

	assign lb_ctrl.rd_en   = accept;
	assign lb_ctrl.rd_addr = col_q;
	assign lb_ctrl.wr_en   = v_s1 && adv;
	assign lb_ctrl.wr_addr = col_s1;

	iis_line_buffer u_line_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lb_ctrl),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	// Output register: it keeps a finished result while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			res.area_sum   <= lb_wr.area;
			res.square_sum <= lb_wr.square;
			res.frame_end  <= last_s1;
		end
	end

`ifndef SYNTHESIS
	// A held stage one keeps its column, so the pending write-back cannot move.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(col_s1))
		else $error("stage one changed while stalled");

	// Intake only stops when both stage one and the output register are full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> v_s1 && res_valid)
		else $error("intake stalled with room in the pipeline");

	// The last pixel of a frame returns the row state to the frame origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix.last_of_frame |=>
			first_row_q && (col_q == '0) && (row_sum_q == '0) && (row_sq_q == '0))
		else $error("frame end did not restart at the origin");

	// Every result that leaves stage one is written back to the line buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv |-> lb_ctrl.wr_en)
		else $error("result left stage one without write-back");
`endif

endmodule

`default_nettype wire

FILE: tb/iis_sum_checker.sv
`default_nettype none

module iis_sum_checker
	import iis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pix_valid,
	input  wire logic                 pix_ready,
	input  wire pixel_in_t            pix,
	input  wire logic                 res_valid,
	input  wire logic                 res_ready,
	input  wire result_t              res,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic                 pready,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [PDATA_W-1:0]   pwdata,
	output int                        mismatches,
	output int                        outstanding,
	output int                        results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [WIDTH_REG_W-1:0] width_reg;
	col_t                   column;
	logic                   top_row;
	logic [ROW_SUM_W-1:0]   row_sum;
	logic [ROW_SQ_W-1:0]    row_sq_sum;
	logic [AREA_W-1:0]      above_area [MAX_WIDTH];
	logic [SQUARE_W-1:0]    above_square [MAX_WIDTH];
	result_t                expected_sums [$];
	result_t                oldest;
	int                     fail_total;
	int                     seen_total;

	function automatic int unsigned row_length(input logic [WIDTH_REG_W-1:0] w);
		if (w == '0)
			return 1;
		if (w > MAX_WIDTH)
			return MAX_WIDTH;
		return w;
	endfunction

	// Advances the integral state by one pixel and returns both sums for it.
	function automatic result_t integrate(input pixel_in_t px);
		result_t              r;
		logic [15:0]          sq;
		logic [AREA_W-1:0]    up_area;
		logic [SQUARE_W-1:0]  up_square;
		int unsigned          x;
		x = column;
		sq = px.pixel * px.pixel;
		row_sum = row_sum + px.pixel;
		row_sq_sum = row_sq_sum + sq;
		up_area = top_row ? '0 : above_area[x];
		up_square = top_row ? '0 : above_square[x];
		r.area_sum = row_sum + up_area;
		r.square_sum = row_sq_sum + up_square;
		r.frame_end = px.last_of_frame;
		above_area[x] = r.area_sum;
		above_square[x] = r.square_sum;
		if (px.last_of_frame || x + 1 >= row_length(width_reg)) begin
			column = '0;
			top_row = px.last_of_frame;
			row_sum = '0;
			row_sq_sum = '0;
		end else begin
			column = col_t'(x + 1);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = IMAGE_WIDTH_RESET;
			column = '0;
			top_row = 1'b1;
			row_sum = '0;
			row_sq_sum = '0;
			expected_sums.delete();
			fail_total = 0;
			seen_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == PADDR_W'(4 * REG_IMAGE_WIDTH)) begin
				width_reg = pwdata[WIDTH_REG_W-1:0];
			end
			if (pix_valid && pix_ready) begin
				expected_sums.push_back(integrate(pix));
			end
			if (res_valid && res_ready) begin
				if (expected_sums.size() == 0) begin
					$error("result transfer with no pixel waiting on it");
					fail_total++;
				end else begin
					oldest = expected_sums.pop_front();
					seen_total++;
					if (res.area_sum !== oldest.area_sum) begin
						$error("area_sum: expected %0d, got %0d", oldest.area_sum, res.area_sum);
						fail_total++;
					end
					if (res.square_sum !== oldest.square_sum) begin
						$error("square_sum: expected %0d, got %0d",
							oldest.square_sum, res.square_sum);
						fail_total++;
					end
					if (res.frame_end !== oldest.frame_end) begin
						$error("frame_end: expected %0b, got %0b", oldest.frame_end, res.frame_end);
						fail_total++;
					end
				end
			end
			mismatches <= fail_total;
			outstanding <= expected_sums.size();
			results_checked <= seen_total;
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import iis_pkg::*;

	// Generous bound on the whole run; a correct run needs a small fraction of it.
	localparam int unsigned CYCLE_LIMIT = 300000;
	// Settling margin after the last predicted result has been taken.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PIXELS_PER_PHASE = 50;

	logic                   clk;
	logic                   arst_n;
	logic                   pix_valid;
	logic                   pix_ready;
	pixel_in_t              pix;
	logic                   res_valid;
	logic                   res_ready;
	result_t                res;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	int                     mismatches;
	int                     outstanding;
	int                     results_checked;

	// Knobs for the handshake traffic, in percent per cycle.
	int unsigned            send_idle_pct = 0;
	int unsigned            stall_pct = 0;
	int unsigned            cycle_count = 0;

	// What the stimulus believes the width register holds, and some counts for the summary.
	logic [WIDTH_REG_W-1:0] width_now = IMAGE_WIDTH_RESET;
	int unsigned            pixels_sent = 0;
	int unsigned            frames_sent = 0;

	integral_image_stream DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// The checker watches every channel, predicts each result and counts failures.
	iis_sum_checker u_sum_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_ready       (pix_ready),
		.pix             (pix),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side stalls at random, at whatever rate the current phase asks for.
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic int unsigned row_length(input logic [WIDTH_REG_W-1:0] w);
		if (w == '0)
			return 1;
		if (w > MAX_WIDTH)
			return MAX_WIDTH;
		return w;
	endfunction

	// Pixel values lean toward the two extremes so that saturated rows show up often.
	function automatic logic [PIXEL_W-1:0] random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIXEL_W'($urandom_range(255));
		endcase
	endfunction

	// Small register values dominate so that frames span many rows for few pixels.
	function automatic int unsigned pick_width();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 2;
			3, 4, 5, 6: return $urandom_range(3, 8);
			7, 8: return $urandom_range(9, 24);
			default: return $urandom_range(25, 64);
		endcase
	endfunction

	// One pixel transfer. The sender may sit idle for a while first; valid then stays
	// high, with the payload held, until the transfer happens.
	task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix.pixel <= value;
		pix.last_of_frame <= last;
		do @(posedge clk); while (!pix_ready);
		pixels_sent++;
		if (last)
			frames_sent++;
	endtask

	// Stops the pixel stream and waits until every predicted result has been taken.
	// The first edge lets the checker count the transfer that just happened.
	task automatic drain_results();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only happen with the block empty. Half of the writes carry
	// junk above the register bits, which the block must drop.
	task automatic set_width(input int unsigned w);
		logic [PDATA_W-1:0] data;
		drain_results();
		data = ($urandom_range(1) == 1) ? PDATA_W'($urandom()) : '0;
		data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
		width_now = WIDTH_REG_W'(w);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_IMAGE_WIDTH);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// A whole frame, closed by a marked last pixel. When allowed, the row length may
	// shrink somewhere inside the frame. It never grows mid-frame, since a longer row
	// would read line buffer columns that this frame never wrote.
	task automatic send_frame(input int unsigned count, input bit saturate, input bit may_shrink);
		int unsigned shrink_at;
		shrink_at = (may_shrink && $urandom_range(2) == 0) ? $urandom_range(1, count) : 0;
		for (int unsigned i = 1; i <= count; i++) begin
			if (i == shrink_at && row_length(width_now) > 1)
				set_width($urandom_range(0, row_length(width_now) - 1));
			send_pixel(saturate ? '1 : random_pixel(), i == count);
		end
	endtask

	initial begin : stimulus
		int unsigned goal;
		int unsigned rows_left;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A frame of one pixel at the reset width.
		send_pixel('1, 1'b1);

		// Rows of three at full brightness, then a dark pixel that ends the frame
		// at the start of a partial row.
		set_width(3);
		repeat (6) send_pixel('1, 1'b0);
		send_pixel('0, 1'b1);

		// A zero register acts as a row length of one: every pixel is its own row.
		set_width(0);
		send_pixel(8'd200, 1'b0);
		send_pixel(8'd17, 1'b0);
		send_pixel('1, 1'b1);

		// Rows of four, then the row shrinks to two while the column already stands
		// past it, so the very next pixel closes its row.
		set_width(4);
		send_pixel(8'd10, 1'b0);
		send_pixel(8'd20, 1'b0);
		send_pixel(8'd30, 1'b0);
		send_pixel(8'd40, 1'b0);
		send_pixel(8'd50, 1'b0);
		send_pixel(8'd60, 1'b0);
		send_pixel(8'd65, 1'b0);
		set_width(2);
		send_pixel(8'd70, 1'b0);
		send_pixel(8'd80, 1'b0);
		send_pixel(8'd90, 1'b1);

		// Random phases, each with its own mix of idle sender and stalling receiver.
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase

			// The widest register values appear only in short frames: saturated pixels
			// at the largest width, and a register value beyond it that must act as
			// the largest width.
			if (phase == 0) begin
				set_width(MAX_WIDTH);
				send_frame(40, 1'b1, 1'b0);
			end
			if (phase == 3) begin
				set_width((1 << WIDTH_REG_W) - 1);
				send_frame(24, 1'b0, 1'b0);
			end

			set_width(pick_width());
			goal = pixels_sent + PIXELS_PER_PHASE;
			while (pixels_sent < goal) begin
				if ($urandom_range(2) == 0)
					set_width(pick_width());
				// Mostly a few rows and a partial one; sometimes an exact number of rows.
				rows_left = $urandom_range(1, 3);
				if ($urandom_range(3) == 0)
					send_frame(rows_left * row_length(width_now), 1'b0, 1'b1);
				else
					send_frame($urandom_range(1, rows_left * row_length(width_now) + 2),
						1'b0, 1'b1);
			end
		end

		drain_results();

		$display("tb_top: %0d pixels in %0d frames, row lengths from one to %0d,", pixels_sent,
			frames_sent, MAX_WIDTH);
		$display("tb_top: four idle and stall mixes, %0d results compared", results_checked);
		if (mismatches == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
